// ===== src/stbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types, constants and helpers for the sorted table binary search
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int POS_W       = IDX_W + 2;
    localparam int CNT_W       = 11;
    localparam int DATA_W      = 32;
    localparam int S_TDATA_W   = ((IDX_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_ENDS,
        ST_CMP,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic load;
        logic rd_last;
        logic rd_mid0;
        logic step;
        logic found_we;
        logic found_val;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic below;
        logic gt;
        logic eq;
        logic empty;
        logic out_free;
    } t_sts;

    function automatic logic [IDX_W-1:0] mid_of(
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi
    );
        logic signed [POS_W:0] s;
        s = {lo[POS_W-1], lo} + {hi[POS_W-1], hi};
        return s[IDX_W:1];
    endfunction

endpackage

// ===== src/stbs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// sequencer for table writes, end checks and the bisection probe loop
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    input  stbs_pkg::t_sts  i_sts,
    output stbs_pkg::t_cmd  o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            stbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == stbs_pkg::OP_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = stbs_pkg::ST_LAST;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            stbs_pkg::ST_LAST: begin
                if (i_sts.n_zero) begin
                    o_cmd.found_we = 1'b1;
                    n_state        = stbs_pkg::ST_PUSH;
                end else begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = stbs_pkg::ST_ENDS;
                end
            end
            stbs_pkg::ST_ENDS: begin
                if (i_sts.below || i_sts.gt) begin
                    o_cmd.found_we = 1'b1;
                    n_state        = stbs_pkg::ST_PUSH;
                end else begin
                    o_cmd.rd_mid0 = 1'b1;
                    n_state       = stbs_pkg::ST_CMP;
                end
            end
            stbs_pkg::ST_CMP: begin
                o_cmd.step = 1'b1;
                if (i_sts.eq || i_sts.empty) begin
                    o_cmd.found_we  = 1'b1;
                    o_cmd.found_val = i_sts.eq;
                    n_state         = stbs_pkg::ST_PUSH;
                end
            end
            stbs_pkg::ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/stbs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_dp
// table memory, search bounds, key compare and output register
// ----------------------------------------------------------------------------
module stbs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [stbs_pkg::CNT_W-1:0]          i_cfg_wr_data,
    input  logic [stbs_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0]  i_item_value,
    input  stbs_pkg::t_cmd                      i_cmd,
    output stbs_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    output logic                                o_out_found,
    input  logic                                i_out_ready
);

    localparam int TD = stbs_pkg::TABLE_DEPTH;
    localparam int IW = stbs_pkg::IDX_W;
    localparam int PW = stbs_pkg::POS_W;
    localparam int CW = stbs_pkg::CNT_W;
    localparam int DW = stbs_pkg::DATA_W;

    logic [DW-1:0]        r_mem [TD];
    logic signed [DW-1:0] r_rdata;
    logic signed [DW-1:0] r_key;
    logic signed [PW-1:0] r_lo;
    logic signed [PW-1:0] r_hi;
    logic [IW-1:0]        r_mid;
    logic [CW-1:0]        r_entry_count;
    logic                 r_n_zero;
    logic                 r_below;
    logic                 r_found;
    logic                 r_out_valid;
    logic                 r_out_found;

    logic [PW-1:0]        cnt_clamp;
    logic signed [PW-1:0] n_lo;
    logic signed [PW-1:0] n_hi;
    logic signed [PW-1:0] mid_ext;
    logic [IW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 gt;
    logic                 eq;

    // covered entries, capped at the table depth
    assign cnt_clamp = (PW'(r_entry_count) > PW'(TD)) ? PW'(TD) : PW'(r_entry_count);

    assign gt      = r_key > r_rdata;
    assign eq      = r_key == r_rdata;
    assign mid_ext = $signed({2'b00, r_mid});
    assign n_lo    = gt ? (mid_ext + PW'(1)) : r_lo;
    assign n_hi    = gt ? r_hi : (mid_ext - PW'(1));

    always_comb begin
        rd_en   = i_cmd.load | i_cmd.rd_last | i_cmd.rd_mid0 | i_cmd.step;
        rd_addr = '0;
        if (i_cmd.rd_last) begin
            rd_addr = r_hi[IW-1:0];
        end else if (i_cmd.rd_mid0) begin
            rd_addr = stbs_pkg::mid_of(r_lo, r_hi);
        end else if (i_cmd.step) begin
            rd_addr = stbs_pkg::mid_of(n_lo, n_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_entry_index] <= i_item_value;
        end
        if (rd_en) begin
            r_rdata <= $signed(r_mem[rd_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CW'(1);
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_item_value;
            r_lo     <= '0;
            r_hi     <= $signed(cnt_clamp) - PW'(1);
            r_n_zero <= (r_entry_count == '0);
        end
        if (i_cmd.rd_last) begin
            r_below <= r_key < r_rdata;
        end
        if (i_cmd.rd_mid0) begin
            r_mid <= stbs_pkg::mid_of(r_lo, r_hi);
        end
        if (i_cmd.step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= stbs_pkg::mid_of(n_lo, n_hi);
        end
        if (i_cmd.found_we) begin
            r_found <= i_cmd.found_val;
        end
        if (i_cmd.push) begin
            r_out_found <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.n_zero   = r_n_zero;
    assign o_sts.below    = r_below;
    assign o_sts.gt       = gt;
    assign o_sts.eq       = eq;
    assign o_sts.empty    = n_lo > n_hi;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_found = r_out_found;

endmodule

// ===== src/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// membership search over a sorted table of signed 32-bit words
// ----------------------------------------------------------------------------
// input stream: tuser selects the kind (0 write, 1 search), tdata carries the
// entry index and the value (table word for a write, key for a search).
// a write stores the word and gives no output transaction.
// a search gives one output transaction, tdata bit 0 = key found.
// a search ends early with a zero count or a key outside the first..last
// range; otherwise it bisects until the key matches or the range is empty;
// each probe is one read of the single-port table memory, issued in the same
// cycle as the previous compare. one search is in flight at a time and tready
// is low while it runs.
// i_cfg_wr_en / i_cfg_wr_data set the number of covered entries; write it only
// while idle. reset sets the count to 1 and clears control state; table
// contents stay undefined until written.
// a stalled receiver holds the result in the output register; the next item is
// still taken, and a following search waits only at its own result hand-off.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [stbs_pkg::CNT_W-1:0]           i_cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index, item_value, zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // key_found, zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int IW = stbs_pkg::IDX_W;
    localparam int DW = stbs_pkg::DATA_W;

    stbs_pkg::t_cmd cmd;
    stbs_pkg::t_sts sts;
    logic           out_found;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_entry_index (s_axis_tdata[IW-1:0]),
        .i_item_value  ($signed(s_axis_tdata[IW+DW-1:IW])),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_found   (out_found),
        .i_out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {(stbs_pkg::M_TDATA_W - 1)'(0), out_found};

endmodule

// ===== src/stbs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_chk
// port-level checks for the sorted table binary search
// ----------------------------------------------------------------------------
module stbs_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [stbs_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    // result holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed under stall");

    // a search occupies the block
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == stbs_pkg::OP_SEARCH)
        |=> !s_axis_tready)
        else $error("input taken during a search");

    // a write does not stall the input
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == stbs_pkg::OP_WRITE)
        |=> s_axis_tready)
        else $error("write stalled the input");

    // a new result only comes out of a running search
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without a search");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[stbs_pkg::M_TDATA_W-1:1] == '0))
        else $error("output pad bits not zero");

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
